/* rtl/ifp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_pkg
// Types, codes and lookup functions shared by the infix to postfix converter.
// ----------------------------------------------------------------------------
package ifp_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int CODE_W          = 3;
  localparam int CHAR_W          = 8;
  localparam int ERR_W           = 2;

  typedef logic [CODE_W-1:0] op_code_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [ERR_W-1:0]  err_t;

  localparam op_code_t OP_OPEN  = 3'd0;
  localparam op_code_t OP_PLUS  = 3'd1;
  localparam op_code_t OP_MINUS = 3'd2;
  localparam op_code_t OP_MUL   = 3'd3;
  localparam op_code_t OP_DIV   = 3'd4;

  localparam char_t CH_OPEN  = 8'h28;
  localparam char_t CH_CLOSE = 8'h29;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_MUL   = 8'h2A;
  localparam char_t CH_DIV   = 8'h2F;
  localparam char_t CH_NONE  = 8'h00;

  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_UNMATCH  = 2'd1;
  localparam err_t ERR_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_OPERAND
  } cls_e;

  typedef struct packed {
    char_t in_char;
    logic  end_of_expr;
  } in_item_t;

  typedef struct packed {
    char_t out_char;
    logic  run_last;
    logic  expr_done;
    err_t  error_code;
  } out_item_t;

  typedef struct packed {
    logic     push;
    logic     pop;
    op_code_t code;
  } stk_ctrl_t;

  typedef struct packed {
    logic     empty;
    logic     full;
    op_code_t top;
  } stk_stat_t;

  function automatic logic [1:0] code_prio(input op_code_t c);
    logic [1:0] p;
    case (c)
      OP_PLUS, OP_MINUS: p = 2'd2;
      OP_MUL, OP_DIV:    p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic char_t code_char(input op_code_t c);
    char_t ch;
    case (c)
      OP_OPEN:  ch = CH_OPEN;
      OP_PLUS:  ch = CH_PLUS;
      OP_MINUS: ch = CH_MINUS;
      OP_MUL:   ch = CH_MUL;
      OP_DIV:   ch = CH_DIV;
      default:  ch = CH_NONE;
    endcase
    return ch;
  endfunction

  function automatic cls_e char_class(input char_t ch);
    cls_e k;
    case (ch)
      CH_OPEN:                          k = CLS_OPEN;
      CH_CLOSE:                         k = CLS_CLOSE;
      CH_PLUS, CH_MINUS, CH_MUL, CH_DIV: k = CLS_OPER;
      default:                          k = CLS_OPERAND;
    endcase
    return k;
  endfunction

  function automatic op_code_t char_code(input char_t ch);
    op_code_t c;
    case (ch)
      CH_PLUS:  c = OP_PLUS;
      CH_MINUS: c = OP_MINUS;
      CH_MUL:   c = OP_MUL;
      CH_DIV:   c = OP_DIV;
      default:  c = OP_OPEN;
    endcase
    return c;
  endfunction

endpackage

/* rtl/ifp_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_cell
// One stack cell: takes the entry above on push, the entry below on pop.
// ----------------------------------------------------------------------------
module ifp_cell
  import ifp_pkg::*;
(
  input  logic      clk_i,
  input  stk_ctrl_t ctrl_i,
  input  op_code_t  up_i,
  input  op_code_t  down_i,
  output op_code_t  code_o
);

  op_code_t code_q, code_d;

  always_comb begin
    code_d = code_q;
    if (ctrl_i.push) begin
      code_d = up_i;
    end else if (ctrl_i.pop) begin
      code_d = down_i;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign code_o = code_q;

endmodule

/* rtl/ifp_stack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_stack
// Operator stack as a shifting chain of cells, top in cell zero, with count.
// ----------------------------------------------------------------------------
module ifp_stack
  import ifp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stk_ctrl_t ctrl_i,
  output stk_stat_t stat_o
);

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(STACK_DEPTH);

  logic [CntW-1:0] count_q, count_d;
  op_code_t        cell_code [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    op_code_t up_w, down_w;
    if (i == 0) begin : g_top
      assign up_w = ctrl_i.code;
    end else begin : g_mid
      assign up_w = cell_code[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down_w = cell_code[i];
    end else begin : g_inner
      assign down_w = cell_code[i+1];
    end
    ifp_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .up_i   (up_w),
      .down_i (down_w),
      .code_o (cell_code[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.push) begin
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q >= DepthC);
  assign stat_o.top   = cell_code[0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("stack count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> (count_q < DepthC) && !ctrl_i.pop)
    else $error("push onto full stack");

  a_pop_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not lower count");

endmodule

/* rtl/infix_to_postfix_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of infix characters into a postfix item stream.
// ----------------------------------------------------------------------------
// An operand or an open bracket is taken in the idle state and a closing
// state then releases its last result. An operator or a close bracket first
// scans the stack, popping one operator per step, before the push or the
// bracket match. An item marked as the end of the expression adds a flush
// step per entry and one more to find the stack empty. The output stall
// holds back each step that releases a result. The pop loop over the stack
// cell chain, one entry a cycle while the output does not stall, sets the
// rate. Results pass through a staging register so the last one of each item
// can carry run_last, then an output register; a new item is taken while the
// previous final result still waits on the output.
module infix_to_postfix_converter
  import ifp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_q, state_d;
  in_item_t   item_q;
  cls_e       cls_q, in_cls;
  op_code_t   code_q, in_code;
  out_item_t  out_q, out_d, stg_q, stg_d, emit_item;
  logic       out_v_q, out_v_d, stg_v_q, stg_v_d;
  logic       emit, out_free, can_step;
  stk_ctrl_t  ctrl;
  stk_stat_t  stat;

  ifp_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  assign in_cls   = char_class(in_item_i.in_char);
  assign in_code  = char_code(in_item_i.in_char);
  assign out_free = !out_v_q || !out_stall_i;
  assign can_step = !stg_v_q || out_free;

  always_comb begin
    state_d   = state_q;
    ctrl      = '0;
    emit      = 1'b0;
    emit_item = '0;
    out_d     = out_q;
    out_v_d   = out_v_q && out_stall_i;
    stg_d     = stg_q;
    stg_v_d   = stg_v_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_cls)
            CLS_OPERAND: begin
              emit               = 1'b1;
              emit_item.out_char = in_item_i.in_char;
              state_d            = in_item_i.end_of_expr ? S_FLUSH : S_FIN;
            end
            CLS_OPEN: begin
              if (!stat.full) begin
                ctrl.push = 1'b1;
                ctrl.code = OP_OPEN;
              end else begin
                emit                 = 1'b1;
                emit_item.error_code = ERR_OVERFLOW;
              end
              state_d = in_item_i.end_of_expr ? S_FLUSH : S_FIN;
            end
            default: begin
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (can_step) begin
          if (cls_q == CLS_CLOSE) begin
            if (!stat.empty && stat.top != OP_OPEN) begin
              ctrl.pop           = 1'b1;
              emit               = 1'b1;
              emit_item.out_char = code_char(stat.top);
            end else begin
              if (!stat.empty) begin
                ctrl.pop = 1'b1;
              end else begin
                emit                 = 1'b1;
                emit_item.error_code = ERR_UNMATCH;
              end
              state_d = item_q.end_of_expr ? S_FLUSH : S_FIN;
            end
          end else begin
            if (!stat.empty && code_prio(code_q) <= code_prio(stat.top)) begin
              ctrl.pop           = 1'b1;
              emit               = 1'b1;
              emit_item.out_char = code_char(stat.top);
            end else begin
              if (!stat.full) begin
                ctrl.push = 1'b1;
                ctrl.code = code_q;
              end else begin
                emit                 = 1'b1;
                emit_item.error_code = ERR_OVERFLOW;
              end
              state_d = item_q.end_of_expr ? S_FLUSH : S_FIN;
            end
          end
        end
      end
      S_FLUSH: begin
        if (can_step) begin
          if (!stat.empty) begin
            ctrl.pop           = 1'b1;
            emit               = 1'b1;
            emit_item.out_char = code_char(stat.top);
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (stg_v_q) begin
          if (out_free) begin
            out_d           = stg_q;
            out_d.run_last  = 1'b1;
            out_d.expr_done = item_q.end_of_expr;
            out_v_d         = 1'b1;
            stg_v_d         = 1'b0;
            state_d         = S_IDLE;
          end
        end else if (item_q.end_of_expr) begin
          if (out_free) begin
            out_d            = '0;
            out_d.run_last   = 1'b1;
            out_d.expr_done  = 1'b1;
            out_d.error_code = ERR_NONE;
            out_v_d          = 1'b1;
            state_d          = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (emit) begin
      if (stg_v_q) begin
        out_d   = stg_q;
        out_v_d = 1'b1;
      end
      stg_d   = emit_item;
      stg_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      stg_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      stg_v_q <= stg_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    stg_q <= stg_d;
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_item_i;
      cls_q  <= in_cls;
      code_q <= in_code;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  a_idle_stage_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !stg_v_q)
    else $error("staged item left behind at idle");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !out_q.expr_done || out_q.run_last)
    else $error("expression end without run end");

  a_error_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.error_code != ERR_NONE |-> out_q.out_char == CH_NONE)
    else $error("error item carries a character");

endmodule
